// File: sv/kpc_pkg.sv
// Shared types, codes and a helper function for the keypad calculator core.
`default_nettype none
package kpc_pkg;

    localparam int DATA_W    = 32;
    localparam int KEY_W     = 5;
    localparam int DIGIT_W   = 4;
    localparam int COUNT_W   = 4;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    // Key codes, row-major on the 4x4 pad
    localparam logic [KEY_W-1:0] KEY_DIV    = 5'd4;
    localparam logic [KEY_W-1:0] KEY_MUL    = 5'd8;
    localparam logic [KEY_W-1:0] KEY_SUB    = 5'd12;
    localparam logic [KEY_W-1:0] KEY_CLEAR  = 5'd13;
    localparam logic [KEY_W-1:0] KEY_EQUALS = 5'd15;
    localparam logic [KEY_W-1:0] KEY_ADD    = 5'd16;

    // Result event kinds
    localparam logic [2:0] EV_DIGIT  = 3'd0;
    localparam logic [2:0] EV_OPER   = 3'd1;
    localparam logic [2:0] EV_RESULT = 3'd2;
    localparam logic [2:0] EV_CLEAR  = 3'd3;
    localparam logic [2:0] EV_IGNORE = 3'd4;

    // Operator codes
    localparam logic [1:0] OP_DIV = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_SUB = 2'd2;
    localparam logic [1:0] OP_ADD = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_DIV0    = 2'd1;
    localparam logic [1:0] ERR_NO_OPER = 2'd2;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_LOCKED = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic cap_key;
        logic decode;
        logic mul_step;
        logic div_step;
        logic load_out;
    } kpc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_mul;
        logic need_div;
        logic div_last;
    } kpc_stat_t;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] value;
    } digit_t;

    function automatic digit_t key_digit(input logic [KEY_W-1:0] key);
        digit_t d;
        d.valid = 1'b1;
        case (key)
            5'd1:    d.value = 4'd7;
            5'd2:    d.value = 4'd8;
            5'd3:    d.value = 4'd9;
            5'd5:    d.value = 4'd4;
            5'd6:    d.value = 4'd5;
            5'd7:    d.value = 4'd6;
            5'd9:    d.value = 4'd1;
            5'd10:   d.value = 4'd2;
            5'd11:   d.value = 4'd3;
            5'd14:   d.value = 4'd0;
            default:
            begin
                d.valid = 1'b0;
                d.value = 4'd0;
            end
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// File: sv/kpc_key_if.sv
// Key code input channel: valid/ready handshake with the key code payload.
`default_nettype none
interface kpc_key_if
    import kpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface
`default_nettype wire

// File: sv/kpc_evt_if.sv
// Result channel: valid/ready handshake with the event payload.
`default_nettype none
interface kpc_evt_if
    import kpc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic [DIGIT_W-1:0] digit_value;
    logic [1:0]         operator_code;
    logic [DATA_W-1:0]  result_value;
    logic [1:0]         error_code;

    modport source (output valid, output event_kind, output digit_value,
                    output operator_code, output result_value, output error_code,
                    input ready);
    modport sink   (input valid, input event_kind, input digit_value,
                    input operator_code, input result_value, input error_code,
                    output ready);
endinterface
`default_nettype wire

// File: sv/keypad_four_function_calculator_core.sv
// Top level of the keypad four-function calculator core.
// Usage:
//   keys    : one 5-bit key code per item (1..16, row-major on a 4x4 pad).
//   results : exactly one event item per key item: digit echo, operator echo,
//             result with error code, cleared, or ignored.
//   An item is taken when the block is idle. Digit, operator, clear, add and
//   subtract items go from decode straight to the output register; multiply
//   adds one registered multiply step; divide by a nonzero divisor runs the
//   restoring divider, which retires one quotient bit per cycle until all 32
//   bits are done. The block is ready for the next key in the cycle after the
//   result is loaded into the output register, and takes no key while one is in work.
//   A result held at the output by a stalled receiver does not block the next
//   key; that key is decoded and its result waits until the output frees up.
//   Reset (rst_n low) clears both operands, digit counts, entry phase and
//   operator, and drops any pending result.
`default_nettype none
module keypad_four_function_calculator_core
    import kpc_pkg::*;
#(
    parameter int MAX_DIGITS = 10
)(
    input wire logic   clk,
    input wire logic   rst_n,
    kpc_key_if.sink    keys,
    kpc_evt_if.source  results
);

    kpc_cmd_t  cmd;
    kpc_stat_t stat;

    kpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (keys.valid),
        .in_ready  (keys.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    kpc_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .key_code      (keys.key_code),
        .event_kind    (results.event_kind),
        .digit_value   (results.digit_value),
        .operator_code (results.operator_code),
        .result_value  (results.result_value),
        .error_code    (results.error_code)
    );

endmodule
`default_nettype wire

// File: sv/kpc_datapath.sv
// Calculator datapath: operand registers, decode, multiplier, serial divider, output register.
`default_nettype none
module kpc_datapath
    import kpc_pkg::*;
#(
    parameter int MAX_DIGITS = 10
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kpc_cmd_t           cmd,
    output kpc_stat_t               stat,
    input  wire logic [KEY_W-1:0]   key_code,
    output logic [2:0]              event_kind,
    output logic [DIGIT_W-1:0]      digit_value,
    output logic [1:0]              operator_code,
    output logic [DATA_W-1:0]       result_value,
    output logic [1:0]              error_code
);

    localparam logic [COUNT_W-1:0] MaxCount = COUNT_W'(MAX_DIGITS);
    localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(DATA_W - 1);

    // Calculator state
    logic [DATA_W-1:0]  a_reg, a_next;
    logic [DATA_W-1:0]  b_reg, b_next;
    logic [COUNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [COUNT_W-1:0] cnt_b_reg, cnt_b_next;
    phase_t             phase_reg, phase_next;
    logic [1:0]         op_reg, op_next;

    // Working registers, no reset needed
    logic [KEY_W-1:0]     key_reg;
    logic [2:0]           pk_kind_reg, pk_kind_next;
    logic [DIGIT_W-1:0]   pk_digit_reg, pk_digit_next;
    logic [1:0]           pk_op_reg, pk_op_next;
    logic [DATA_W-1:0]    pk_value_reg, pk_value_next;
    logic [1:0]           pk_err_reg, pk_err_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic [2:0]         out_kind_reg;
    logic [DIGIT_W-1:0] out_digit_reg;
    logic [1:0]         out_op_reg;
    logic [DATA_W-1:0]  out_value_reg;
    logic [1:0]         out_err_reg;

    digit_t          dig;
    logic            is_oper;
    logic [1:0]      key_op;
    logic            is_eq;
    logic            has_oper;
    logic [DATA_W:0] rem_shift;
    logic [DATA_W:0] rem_diff;
    logic [DATA_W-1:0] quo_shift;

    always_comb
    begin
        dig     = key_digit(key_reg);
        is_oper = 1'b1;
        key_op  = OP_DIV;
        case (key_reg)
            KEY_DIV: key_op = OP_DIV;
            KEY_MUL: key_op = OP_MUL;
            KEY_SUB: key_op = OP_SUB;
            KEY_ADD: key_op = OP_ADD;
            default: is_oper = 1'b0;
        endcase
        is_eq    = (key_reg == KEY_EQUALS);
        has_oper = (phase_reg != PH_FIRST);
    end

    assign stat.need_mul = is_eq && has_oper && (op_reg == OP_MUL);
    assign stat.need_div = is_eq && has_oper && (op_reg == OP_DIV) && (b_reg != '0);
    assign stat.div_last = (div_cnt_reg == DivLast);

    // One restoring step per cycle
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, b_reg};
    assign quo_shift = {quo_reg[DATA_W-2:0], ~rem_diff[DATA_W]};

    always_comb
    begin
        a_next        = a_reg;
        b_next        = b_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        phase_next    = phase_reg;
        op_next       = op_reg;
        pk_kind_next  = pk_kind_reg;
        pk_digit_next = pk_digit_reg;
        pk_op_next    = pk_op_reg;
        pk_value_next = pk_value_reg;
        pk_err_next   = pk_err_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        div_cnt_next  = div_cnt_reg;

        if (cmd.decode)
        begin
            pk_kind_next  = EV_IGNORE;
            pk_digit_next = '0;
            pk_op_next    = OP_DIV;
            pk_value_next = '0;
            pk_err_next   = ERR_NONE;
            rem_next      = '0;
            quo_next      = a_reg;
            div_cnt_next  = '0;
            if (key_reg == KEY_CLEAR)
            begin
                a_next       = '0;
                b_next       = '0;
                cnt_a_next   = '0;
                cnt_b_next   = '0;
                phase_next   = PH_FIRST;
                op_next      = OP_DIV;
                pk_kind_next = EV_CLEAR;
            end
            else if (is_oper)
            begin
                op_next      = key_op;
                pk_kind_next = EV_OPER;
                pk_op_next   = key_op;
                if (phase_reg == PH_FIRST)
                    phase_next = PH_SECOND;
                else
                    phase_next = PH_LOCKED;
            end
            else if (is_eq)
            begin
                pk_kind_next = EV_RESULT;
                if (!has_oper)
                    pk_err_next = ERR_NO_OPER;
                else
                begin
                    case (op_reg)
                        OP_DIV:
                        begin
                            if (b_reg == '0)
                                pk_err_next = ERR_DIV0;
                        end
                        OP_SUB:  pk_value_next = a_reg - b_reg;
                        OP_ADD:  pk_value_next = a_reg + b_reg;
                        default: pk_value_next = '0;
                    endcase
                end
            end
            else if (dig.valid)
            begin
                // operand * 10 + digit
                if (phase_reg == PH_FIRST && cnt_a_reg < MaxCount)
                begin
                    a_next = {a_reg[DATA_W-4:0], 3'b000} + {a_reg[DATA_W-2:0], 1'b0}
                             + DATA_W'(dig.value);
                    cnt_a_next    = cnt_a_reg + 1'b1;
                    pk_kind_next  = EV_DIGIT;
                    pk_digit_next = dig.value;
                end
                else if (phase_reg == PH_SECOND && cnt_b_reg < MaxCount)
                begin
                    b_next = {b_reg[DATA_W-4:0], 3'b000} + {b_reg[DATA_W-2:0], 1'b0}
                             + DATA_W'(dig.value);
                    cnt_b_next    = cnt_b_reg + 1'b1;
                    pk_kind_next  = EV_DIGIT;
                    pk_digit_next = dig.value;
                end
            end
        end

        if (cmd.mul_step)
            pk_value_next = a_reg * b_reg;

        if (cmd.div_step)
        begin
            if (!rem_diff[DATA_W])
                rem_next = rem_diff[DATA_W-1:0];
            else
                rem_next = rem_shift[DATA_W-1:0];
            quo_next     = quo_shift;
            div_cnt_next = div_cnt_reg + 1'b1;
            if (stat.div_last)
                pk_value_next = quo_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg     <= '0;
            b_reg     <= '0;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            phase_reg <= PH_FIRST;
            op_reg    <= OP_DIV;
        end
        else
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            phase_reg <= phase_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_key)
            key_reg <= key_code;
        pk_kind_reg  <= pk_kind_next;
        pk_digit_reg <= pk_digit_next;
        pk_op_reg    <= pk_op_next;
        pk_value_reg <= pk_value_next;
        pk_err_reg   <= pk_err_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        div_cnt_reg  <= div_cnt_next;
        if (cmd.load_out)
        begin
            out_kind_reg  <= pk_kind_reg;
            out_digit_reg <= pk_digit_reg;
            out_op_reg    <= pk_op_reg;
            out_value_reg <= pk_value_reg;
            out_err_reg   <= pk_err_reg;
        end
    end

    assign event_kind    = out_kind_reg;
    assign digit_value   = out_digit_reg;
    assign operator_code = out_op_reg;
    assign result_value  = out_value_reg;
    assign error_code    = out_err_reg;

endmodule
`default_nettype wire

// File: sv/kpc_ctrl.sv
// Calculator controller: sequences decode, multiply and divide, owns the handshakes.
`default_nettype none
module kpc_ctrl
    import kpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire kpc_stat_t stat,
    output kpc_cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.cap_key = in_valid;
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.need_mul)
                    state_next = ST_MUL;
                else if (stat.need_div)
                    state_next = ST_DIV;
                else
                    state_next = ST_EMIT;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold here while the previous item still waits at the output
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: sv/kpc_checker.sv
// Port-level assertions for the calculator core, bound to the top level.
`default_nettype none
module kpc_checker
    import kpc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [2:0]         event_kind,
    input wire logic [DIGIT_W-1:0] digit_value,
    input wire logic [1:0]         operator_code,
    input wire logic [DATA_W-1:0]  result_value,
    input wire logic [1:0]         error_code
);

    // A result waiting at the output stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // One key at a time: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("key accepted while previous key still in work");

    // Digit echo carries only a decimal digit
    a_digit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_DIGIT |->
            digit_value <= 4'd9 && operator_code == OP_DIV
            && result_value == '0 && error_code == ERR_NONE)
        else $error("malformed digit echo");

    // An error result carries a zero value
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |->
            event_kind == EV_RESULT && result_value == '0)
        else $error("error code outside a zero result");

endmodule

bind keypad_four_function_calculator_core kpc_checker u_kpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (keys.valid),
    .in_ready      (keys.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .event_kind    (results.event_kind),
    .digit_value   (results.digit_value),
    .operator_code (results.operator_code),
    .result_value  (results.result_value),
    .error_code    (results.error_code)
);
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the keypad four-function calculator core.
`timescale 1ns / 1ps
module testbench;
    import kpc_pkg::*;

    localparam int DIGITS_MAX   = 10;
    localparam int KEY_ITEMS    = 650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [2:0]         kind;
        logic [DIGIT_W-1:0] digit;
        logic [1:0]         oper;
        logic [DATA_W-1:0]  value;
        logic [1:0]         err;
    } key_event_t;

    logic clk;
    logic rst_n;

    kpc_key_if key_bus ();
    kpc_evt_if evt_bus ();

    keypad_four_function_calculator_core #(
        .MAX_DIGITS (DIGITS_MAX)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .keys    (key_bus),
        .results (evt_bus)
    );

    // Calculator state as the keys should leave it
    logic [DATA_W-1:0]  acc_first;
    logic [DATA_W-1:0]  acc_second;
    logic [COUNT_W-1:0] cnt_first;
    logic [COUNT_W-1:0] cnt_second;
    phase_t             acc_phase;
    logic [1:0]         acc_op;

    key_event_t pending_events[$];

    int  cycle_count;
    int  fail_count;
    int  keys_sent;
    int  keys_counted;
    int  events_checked;
    int  kind_seen [5];
    int  div0_seen;
    int  no_oper_seen;
    int  hold_off;
    bit  steady;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_events.size());
            $display("keypad_four_function_calculator_core: mismatch");
            $finish;
        end
    end

    function automatic logic [KEY_W-1:0] digit_key(input int d);
        case (d)
            0: return 5'd14;
            1: return 5'd9;
            2: return 5'd10;
            3: return 5'd11;
            4: return 5'd5;
            5: return 5'd6;
            6: return 5'd7;
            7: return 5'd1;
            8: return 5'd2;
            default: return 5'd3;
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] oper_key(input int i);
        case (i)
            0: return KEY_DIV;
            1: return KEY_MUL;
            2: return KEY_SUB;
            default: return KEY_ADD;
        endcase
    endfunction

    // -1 when the key is not a digit
    function automatic int pad_digit(input logic [KEY_W-1:0] key);
        for (int d = 0; d < 10; d++)
            if (digit_key(d) == key)
                return d;
        return -1;
    endfunction

    function automatic void clear_calc();
        acc_first  = '0;
        acc_second = '0;
        cnt_first  = '0;
        cnt_second = '0;
        acc_phase  = PH_FIRST;
        acc_op     = OP_DIV;
    endfunction

    function automatic key_event_t calc_key(input logic [KEY_W-1:0] key);
        key_event_t ev;
        int         d;
        ev      = '0;
        ev.kind = EV_IGNORE;
        d       = pad_digit(key);
        if (key == KEY_CLEAR)
        begin
            clear_calc();
            ev.kind = EV_CLEAR;
        end
        else if (key == KEY_DIV || key == KEY_MUL || key == KEY_SUB || key == KEY_ADD)
        begin
            case (key)
                KEY_DIV: acc_op = OP_DIV;
                KEY_MUL: acc_op = OP_MUL;
                KEY_SUB: acc_op = OP_SUB;
                default: acc_op = OP_ADD;
            endcase
            if (acc_phase != PH_LOCKED)
                acc_phase = phase_t'(acc_phase + 2'd1);
            ev.kind = EV_OPER;
            ev.oper = acc_op;
        end
        else if (key == KEY_EQUALS)
        begin
            ev.kind = EV_RESULT;
            if (acc_phase == PH_FIRST)
                ev.err = ERR_NO_OPER;
            else
            begin
                case (acc_op)
                    OP_DIV:
                    begin
                        if (acc_second == '0)
                            ev.err = ERR_DIV0;
                        else
                            ev.value = acc_first / acc_second;
                    end
                    OP_MUL: ev.value = acc_first * acc_second;
                    OP_SUB: ev.value = acc_first - acc_second;
                    default: ev.value = acc_first + acc_second;
                endcase
            end
        end
        else if (d >= 0)
        begin
            if (acc_phase == PH_FIRST && cnt_first < DIGITS_MAX)
            begin
                acc_first = acc_first * 10 + DATA_W'(d);
                cnt_first++;
                ev.kind  = EV_DIGIT;
                ev.digit = DIGIT_W'(d);
            end
            else if (acc_phase == PH_SECOND && cnt_second < DIGITS_MAX)
            begin
                acc_second = acc_second * 10 + DATA_W'(d);
                cnt_second++;
                ev.kind  = EV_DIGIT;
                ev.digit = DIGIT_W'(d);
            end
        end
        return ev;
    endfunction

    // Result side: random stalls, long hold-off on request
    initial
    begin
        evt_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                evt_bus.ready <= 1'b0;
            end
            else
                evt_bus.ready <= steady || ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        key_event_t got;
        key_event_t want;
        if (rst_n && evt_bus.valid && evt_bus.ready)
        begin
            got.kind  = evt_bus.event_kind;
            got.digit = evt_bus.digit_value;
            got.oper  = evt_bus.operator_code;
            got.value = evt_bus.result_value;
            got.err   = evt_bus.error_code;
            if (pending_events.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result item: kind %0d digit %0d op %0d value %0d err %0d",
                             got.kind, got.digit, got.oper, got.value, got.err);
            end
            else
            begin
                want = pending_events.pop_front();
                events_checked++;
                if (want.kind < 5)
                    kind_seen[want.kind]++;
                if (want.err == ERR_DIV0)
                    div0_seen++;
                if (want.err == ERR_NO_OPER)
                    no_oper_seen++;
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("result %0d wrong: expected kind %0d digit %0d op %0d value %0d err %0d, got kind %0d digit %0d op %0d value %0d err %0d",
                                 events_checked, want.kind, want.digit, want.oper, want.value,
                                 want.err, got.kind, got.digit, got.oper, got.value, got.err);
                end
            end
        end
    end

    task automatic send_key(input logic [KEY_W-1:0] key);
        key_event_t ev;
        key_bus.valid    <= 1'b1;
        key_bus.key_code <= key;
        do
            @(posedge clk);
        while (!key_bus.ready);
        ev = calc_key(key);
        pending_events.push_back(ev);
        keys_sent++;
        if (ev.kind != EV_IGNORE)
            keys_counted++;
        if (!steady && $urandom_range(0, 99) < 30)
        begin
            key_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    function automatic int pick_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 4);
        return $urandom_range(5, DIGITS_MAX + 1);
    endfunction

    task automatic send_number(input int len);
        repeat (len) send_key(digit_key($urandom_range(0, 9)));
    endtask

    // One calculation with random content, now and then broken or pure noise
    task automatic send_calculation();
        logic [KEY_W-1:0] op_key;
        op_key = oper_key($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 3)) send_key(KEY_W'($urandom_range(0, 31)));
        else
        begin
            if ($urandom_range(0, 99) < 60)
                send_key(KEY_CLEAR);
            send_number(pick_len());
            if ($urandom_range(0, 99) >= 5)
            begin
                send_key(op_key);
                if ($urandom_range(0, 99) < 15)
                    send_key(digit_key(0));
                else
                    send_number(pick_len());
                // second operator locks entry, digits after it are dropped
                if ($urandom_range(0, 99) < 10)
                begin
                    send_key(oper_key($urandom_range(0, 3)));
                    send_number(2);
                end
            end
            send_key(KEY_EQUALS);
            if ($urandom_range(0, 99) < 20)
            begin
                send_key(oper_key($urandom_range(0, 3)));
                send_key(KEY_EQUALS);
            end
        end
    endtask

    task automatic run_calculations(input int upto);
        while (keys_counted < upto)
            send_calculation();
    endtask

    task automatic test_equals_without_operator();
        send_key(KEY_EQUALS);
    endtask

    task automatic test_out_of_range_codes();
        send_key('0);
        send_key('1);
        send_key(KEY_ADD + 5'd1);
    endtask

    task automatic test_digit_limit();
        for (int d = 9; d >= 0; d--)
            send_key(digit_key(d));
        send_key(digit_key(9));
    endtask

    task automatic test_divide_by_zero();
        send_key(KEY_DIV);
        send_key(KEY_EQUALS);
    endtask

    task automatic test_locked_entry();
        send_key(KEY_ADD);
        send_key(digit_key(5));
        send_key(KEY_EQUALS);
        send_key(KEY_MUL);
        send_key(KEY_SUB);
        send_key(KEY_EQUALS);
    endtask

    task automatic test_clear();
        send_key(KEY_CLEAR);
        send_key(digit_key(1));
        send_key(KEY_SUB);
        send_key(digit_key(2));
        send_key(KEY_EQUALS);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        run_calculations(keys_counted + 100);
        steady = 1'b0;
    endtask

    task automatic test_output_stall();
        hold_off = 300;
        run_calculations(keys_counted + 20);
    endtask

    task automatic test_random_calculations();
        run_calculations(KEY_ITEMS);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        key_bus.valid    = 1'b0;
        key_bus.key_code = '0;
        cycle_count      = 0;
        fail_count       = 0;
        keys_sent        = 0;
        keys_counted     = 0;
        events_checked   = 0;
        div0_seen        = 0;
        no_oper_seen     = 0;
        hold_off         = 0;
        steady           = 1'b0;
        foreach (kind_seen[i])
            kind_seen[i] = 0;
        clear_calc();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_equals_without_operator();
        test_out_of_range_codes();
        test_digit_limit();
        test_divide_by_zero();
        test_locked_entry();
        test_clear();
        test_back_to_back();
        test_output_stall();
        test_random_calculations();

        key_bus.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_events.size() != 0)
            fail_count++;

        $display("%0d keys sent, %0d results checked: %0d digits, %0d operators, %0d results, %0d clears, %0d ignored",
                 keys_sent, events_checked, kind_seen[EV_DIGIT], kind_seen[EV_OPER],
                 kind_seen[EV_RESULT], kind_seen[EV_CLEAR], kind_seen[EV_IGNORE]);
        $display("divide-by-zero results %0d, missing-operator results %0d, failures %0d",
                 div0_seen, no_oper_seen, fail_count);
        if (fail_count == 0)
            $display("keypad_four_function_calculator_core: match");
        else
            $display("keypad_four_function_calculator_core: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
sv/kpc_pkg.sv
sv/kpc_key_if.sv
sv/kpc_evt_if.sv
sv/kpc_datapath.sv
sv/kpc_ctrl.sv
sv/keypad_four_function_calculator_core.sv
sv/kpc_checker.sv
tb/testbench.sv
